// ----- design/ssbt_pkg.sv -----
// Package for the sprite sort and batch block: constants, state enum,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package ssbt_pkg;

    localparam int MAX_ITEMS      = 64;
    localparam int VERTS_PER_ITEM = 6;
    localparam int IDX_W          = 6;   // store address
    localparam int CNT_W          = 7;   // record count, 0..MAX_ITEMS
    localparam int VTX_W          = 9;

    localparam logic       OP_ADD = 1'b0;
    localparam logic       OP_END = 1'b1;

    localparam logic [1:0] MODE_TEX_ASC = 2'd0;
    localparam logic [1:0] MODE_DEP_ASC = 2'd1;
    localparam logic [1:0] MODE_DEP_DSC = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_LD,
        ST_CMP_RD,
        ST_CMP,
        ST_WR,
        ST_RUN_ORD,
        ST_RUN_TEX,
        ST_RUN_CHK,
        ST_EM_ORD,
        ST_EM_TEX,
        ST_EM_LOAD,
        ST_EM_WAIT
    } state_t;

    typedef struct packed {
        logic add;        // store the accepted record
        logic begin_end;  // end word accepted: reset sort/run counters
        logic key_rd;
        logic key_ld;
        logic cmp_rd;
        logic cmp;
        logic wr;
        logic run_ord;
        logic run_tex;
        logic run_chk;
        logic em_ord;
        logic em_tex;
        logic em_load;
        logic em_adv;     // result word taken
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cmp_last;
        logic i_last;
        logic run_match;
        logic run_at_end;
        logic em_run_done;
        logic em_all_done;
    } status_t;

endpackage
`default_nettype wire

// ----- design/ssbt_ctrl.sv -----
// Sequencer for the sort and batch block: rank pass, run scan, emission.
// Depends on ssbt_pkg.
`default_nettype none
module ssbt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             opcode,
    input  wire logic             out_ready,
    input  ssbt_pkg::status_t     sts,
    output logic                  in_ready,
    output logic                  out_valid,
    output ssbt_pkg::cmd_t        cmd
);
    import ssbt_pkg::*;

    state_t state_reg, state_next;
    logic   in_acc;

    assign in_acc = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && opcode == OP_END && !sts.cnt_zero)
                    state_next = ST_KEY_RD;
            end
            ST_KEY_RD:  state_next = ST_KEY_LD;
            ST_KEY_LD:  state_next = ST_CMP_RD;
            ST_CMP_RD:  state_next = ST_CMP;
            ST_CMP:     state_next = sts.cmp_last ? ST_WR : ST_CMP_RD;
            ST_WR:      state_next = sts.i_last ? ST_RUN_ORD : ST_KEY_RD;
            ST_RUN_ORD: state_next = ST_RUN_TEX;
            ST_RUN_TEX: state_next = ST_RUN_CHK;
            ST_RUN_CHK:
            begin
                if (sts.run_match && !sts.run_at_end)
                    state_next = ST_RUN_ORD;
                else
                    state_next = ST_EM_ORD;
            end
            ST_EM_ORD:  state_next = ST_EM_TEX;
            ST_EM_TEX:  state_next = ST_EM_LOAD;
            ST_EM_LOAD: state_next = ST_EM_WAIT;
            ST_EM_WAIT:
            begin
                if (out_ready)
                begin
                    if (sts.em_all_done)
                        state_next = ST_IDLE;
                    else if (sts.em_run_done)
                        state_next = ST_RUN_ORD;
                    else
                        state_next = ST_EM_ORD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.add       = in_acc && opcode == OP_ADD;
                cmd.begin_end = in_acc && opcode == OP_END;
            end
            ST_KEY_RD:  cmd.key_rd  = 1'b1;
            ST_KEY_LD:  cmd.key_ld  = 1'b1;
            ST_CMP_RD:  cmd.cmp_rd  = 1'b1;
            ST_CMP:     cmd.cmp     = 1'b1;
            ST_WR:      cmd.wr      = 1'b1;
            ST_RUN_ORD: cmd.run_ord = 1'b1;
            ST_RUN_TEX: cmd.run_tex = 1'b1;
            ST_RUN_CHK: cmd.run_chk = 1'b1;
            ST_EM_ORD:  cmd.em_ord  = 1'b1;
            ST_EM_TEX:  cmd.em_tex  = 1'b1;
            ST_EM_LOAD: cmd.em_load = 1'b1;
            ST_EM_WAIT:
            begin
                out_valid  = 1'b1;
                cmd.em_adv = out_ready;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/ssbt_dp.sv -----
// Datapath: record stores, sort order memory, rank counters, run tracking
// and the result register. Depends on ssbt_pkg.
`default_nettype none
module ssbt_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  ssbt_pkg::cmd_t                    cmd,
    input  wire logic                         mode_we,
    input  wire logic [1:0]                   mode_wdata,
    input  wire logic [31:0]                  texture_id,
    input  wire logic signed [31:0]           depth,
    output ssbt_pkg::status_t                 sts,
    output logic [ssbt_pkg::IDX_W-1:0]        item_index,
    output logic [31:0]                       texture_out,
    output logic [ssbt_pkg::IDX_W-1:0]        batch_number,
    output logic                              batch_first,
    output logic                              batch_last,
    output logic [ssbt_pkg::VTX_W-1:0]        batch_vertex_offset,
    output logic [ssbt_pkg::VTX_W-1:0]        batch_vertex_count,
    output logic                              overflow,
    output logic                              last
);
    import ssbt_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
    localparam logic [VTX_W-1:0] VPI     = VTX_W'(VERTS_PER_ITEM);

    logic [31:0]       tex_mem [MAX_ITEMS];
    logic [31:0]       dep_mem [MAX_ITEMS];
    logic [IDX_W-1:0]  ord_mem [MAX_ITEMS];

    logic [31:0]       tex_q_reg, dep_q_reg;
    logic [IDX_W-1:0]  ord_q_reg;
    logic [1:0]        mode_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  count_reg, i_reg, j_reg, rank_reg, p_reg, q_reg, start_reg;
    logic [IDX_W-1:0]  batch_reg;
    logic [31:0]       key_tex_reg, key_dep_reg, run_tex_reg;

    logic [IDX_W-1:0]  sd_addr;
    logic              sd_rd;
    logic              less_ji, less_ij, j_first;

    // store read address: own key, compare partner, or record from order
    always_comb
    begin
        sd_rd   = cmd.key_rd | cmd.cmp_rd | cmd.run_tex | cmd.em_tex;
        sd_addr = ord_q_reg;
        if (cmd.key_rd)
            sd_addr = i_reg[IDX_W-1:0];
        else if (cmd.cmp_rd)
            sd_addr = j_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add && count_reg != CNT_MAX)
        begin
            tex_mem[count_reg[IDX_W-1:0]] <= texture_id;
            dep_mem[count_reg[IDX_W-1:0]] <= depth;
        end
        if (sd_rd)
        begin
            tex_q_reg <= tex_mem[sd_addr];
            dep_q_reg <= dep_mem[sd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            ord_mem[rank_reg[IDX_W-1:0]] <= i_reg[IDX_W-1:0];
        if (cmd.run_ord)
            ord_q_reg <= ord_mem[p_reg[IDX_W-1:0]];
        else if (cmd.em_ord)
            ord_q_reg <= ord_mem[q_reg[IDX_W-1:0]];
    end

    // key order between partner j (in read regs) and record i (in key regs)
    always_comb
    begin
        case (mode_reg)
            MODE_TEX_ASC:
            begin
                less_ji = tex_q_reg < key_tex_reg;
                less_ij = key_tex_reg < tex_q_reg;
            end
            MODE_DEP_ASC:
            begin
                less_ji = $signed(dep_q_reg) < $signed(key_dep_reg);
                less_ij = $signed(key_dep_reg) < $signed(dep_q_reg);
            end
            MODE_DEP_DSC:
            begin
                less_ji = $signed(dep_q_reg) > $signed(key_dep_reg);
                less_ij = $signed(key_dep_reg) > $signed(dep_q_reg);
            end
            default:
            begin
                less_ji = 1'b0;
                less_ij = 1'b0;
            end
        endcase
        // ties keep arrival order
        j_first = less_ji || (!less_ij && j_reg < i_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEX_ASC;
            ovf_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (mode_we)
                mode_reg <= mode_wdata;
            if (cmd.add)
            begin
                if (count_reg == CNT_MAX)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.em_adv && sts.em_all_done)
                count_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_end)
        begin
            i_reg     <= '0;
            p_reg     <= '0;
            start_reg <= '0;
            batch_reg <= '0;
        end
        if (cmd.key_ld)
        begin
            key_tex_reg <= tex_q_reg;
            key_dep_reg <= dep_q_reg;
            j_reg       <= '0;
            rank_reg    <= '0;
        end
        if (cmd.cmp)
        begin
            if (j_first)
                rank_reg <= rank_reg + 1'b1;
            j_reg <= j_reg + 1'b1;
        end
        if (cmd.wr)
            i_reg <= i_reg + 1'b1;
        if (cmd.run_chk)
        begin
            if (p_reg == start_reg)
                run_tex_reg <= tex_q_reg;
            if (sts.run_match)
                p_reg <= p_reg + 1'b1;
            q_reg <= start_reg;
        end
        if (cmd.em_adv)
        begin
            q_reg <= q_reg + 1'b1;
            if (sts.em_run_done)
            begin
                start_reg <= p_reg;
                batch_reg <= batch_reg + 1'b1;
            end
        end
        if (cmd.em_load)
        begin
            item_index          <= ord_q_reg;
            texture_out         <= tex_q_reg;
            batch_number        <= batch_reg;
            batch_first         <= q_reg == start_reg;
            batch_last          <= q_reg + 1'b1 == p_reg;
            batch_vertex_offset <= VTX_W'(start_reg) * VPI;
            batch_vertex_count  <= VTX_W'(p_reg - start_reg) * VPI;
            overflow            <= ovf_reg;
            last                <= q_reg + 1'b1 == count_reg;
        end
    end

    always_comb
    begin
        sts.cnt_zero    = count_reg == '0;
        sts.cmp_last    = j_reg + 1'b1 == count_reg;
        sts.i_last      = i_reg + 1'b1 == count_reg;
        sts.run_match   = (p_reg == start_reg) || (tex_q_reg == run_tex_reg);
        sts.run_at_end  = p_reg + 1'b1 == count_reg;
        sts.em_run_done = q_reg + 1'b1 == p_reg;
        sts.em_all_done = q_reg + 1'b1 == count_reg;
    end

endmodule
`default_nettype wire

// ----- design/stable_sort_and_batch_by_texture.sv -----
// Sprite sort and batch, top level. Add word: no result.
// End word with n records: rank pass, then per batch a run scan of its
// records and one result word per record (held while out_ready stalls).
// One word at a time; in_ready is high only while idle.
// rst_n (async, active low) clears record count, overflow flag, sort_mode.
// Stores hold garbage after reset; only written entries are ever read.
`default_nettype none
module stable_sort_and_batch_by_texture (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          opcode,
    input  wire logic [31:0]                   texture_id,
    input  wire logic signed [31:0]            depth,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ssbt_pkg::IDX_W-1:0]         item_index,
    output logic [31:0]                        texture_out,
    output logic [ssbt_pkg::IDX_W-1:0]         batch_number,
    output logic                               batch_first,
    output logic                               batch_last,
    output logic [ssbt_pkg::VTX_W-1:0]         batch_vertex_offset,
    output logic [ssbt_pkg::VTX_W-1:0]         batch_vertex_count,
    output logic                               overflow,
    output logic                               last,
    input  wire logic                          sort_mode_we,
    input  wire logic [1:0]                    sort_mode
);
    import ssbt_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Controller: walks rank computation (each record counted against all
    // others, stable on ties), then per batch a run scan and the emission.
    ssbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (opcode),
        .out_ready (out_ready),
        .sts       (sts),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Datapath: stores, order memory, counters, result word register.
    ssbt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .mode_we             (sort_mode_we),
        .mode_wdata          (sort_mode),
        .texture_id          (texture_id),
        .depth               (depth),
        .sts                 (sts),
        .item_index          (item_index),
        .texture_out         (texture_out),
        .batch_number        (batch_number),
        .batch_first         (batch_first),
        .batch_last          (batch_last),
        .batch_vertex_offset (batch_vertex_offset),
        .batch_vertex_count  (batch_vertex_count),
        .overflow            (overflow),
        .last                (last)
    );

endmodule
`default_nettype wire

// ----- design/ssbt_chk.sv -----
// Port-level checker for the sort and batch block, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module ssbt_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic opcode,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while results pending");

    a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !opcode |=> !out_valid)
        else $error("add word produced a result");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready && !out_valid)
        else $error("not idle after final result");

endmodule

bind stable_sort_and_batch_by_texture ssbt_chk u_ssbt_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last)
);
`default_nettype wire
